// ===== src/dtdc_pkg.sv =====
// ----------------------------------------------------------------------------
// dtdc_pkg
// Shared codes for the descriptor table dedup cache: result status, register
// map and sequencer states.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dtdc_pkg;

  localparam int unsigned PADDR_W = 5;
  localparam int unsigned PDATA_W = 64;

  localparam logic [1:0] ST_HIT   = 2'd0;
  localparam logic [1:0] ST_ALLOC = 2'd1;
  localparam logic [1:0] ST_NOEN  = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;

  localparam logic [1:0] REG_ENABLE   = 2'd0;
  localparam logic [1:0] REG_CAPACITY = 2'd1;
  localparam logic [1:0] REG_STRIDE   = 2'd2;
  localparam logic [1:0] REG_BASE     = 2'd3;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_MUL  = 2'd2;
  localparam logic [1:0] S_ADD  = 2'd3;

endpackage

// ===== src/descriptor_table_dedup_cache_top.sv =====
// ----------------------------------------------------------------------------
// descriptor_table_dedup_cache_top
// Dedups hash pairs into bump-allocated slots and returns the address of the
// slot's two-descriptor table in the heap.
// ----------------------------------------------------------------------------
// Sequence: a disabled store goes straight to the result register; otherwise
//   a slot memory scan of one read per cycle over the slots in use and a
//   compare, then one multiply and one add; a full store skips the multiply.
// Throughput: one request in flight; the next is taken the cycle after the
//   result is registered, even while that result still waits.
// Reset: clears slot count, control and registers except rd_data_q; slot memory is not cleared.
`timescale 1ns / 1ps

module descriptor_table_dedup_cache_top
  import dtdc_pkg::*;
#(
  parameter int unsigned MAX_TABLES = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [PDATA_W-1:0]  pwdata,
  output logic [PDATA_W-1:0]  prdata,
  output logic                pready,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [63:0]         key_hash_a_i,
  input  logic [63:0]         key_hash_b_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [1:0]          status_o,
  output logic [7:0]          slot_index_o,
  output logic [63:0]         table_address_o,
  output logic [8:0]          slots_used_o
);

  localparam int unsigned IdxW = (MAX_TABLES > 1) ? $clog2(MAX_TABLES) : 1;
  localparam int unsigned CntW = $clog2(MAX_TABLES + 1);
  localparam int unsigned CapW = (CntW > 9) ? CntW : 9;
  localparam int unsigned PrdW = IdxW + 16;

  logic                en_q;
  logic [8:0]          cap_q;
  logic [15:0]         stride_q;
  logic [63:0]         base_q;

  logic [127:0]        mem [MAX_TABLES];
  logic [127:0]        rd_data_q;
  logic                rd_vld_q;
  logic [IdxW-1:0]     rd_idx_q;

  logic [1:0]          state_q;
  logic [63:0]         ka_q, kb_q;
  logic [CntW-1:0]     ptr_q;
  logic [CntW-1:0]     cnt_q;
  logic [IdxW-1:0]     idx_q;
  logic [1:0]          rs_q;
  logic [PrdW-1:0]     prod_q;

  logic                out_valid_q;
  logic [1:0]          status_q;
  logic [7:0]          slot_q;
  logic [63:0]         addr_q;
  logic [8:0]          used_q;

  logic                cfg_wr;
  logic                issue;
  logic                match;
  logic                done_miss;
  logic                full;
  logic                alloc_en;
  logic                out_free;
  logic                out_load;
  logic                ok;
  logic [CapW-1:0]     cap_ext, eff_cap;
  logic [63:0]         addr_d;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_comb begin
    case (paddr[4:3])
      REG_ENABLE:   prdata = 64'(en_q);
      REG_CAPACITY: prdata = 64'(cap_q);
      REG_STRIDE:   prdata = 64'(stride_q);
      REG_BASE:     prdata = base_q;
      default:      prdata = '0;
    endcase
  end

  assign cap_ext   = CapW'(cap_q);
  assign eff_cap   = (cap_ext > CapW'(MAX_TABLES)) ? CapW'(MAX_TABLES) : cap_ext;
  assign full      = CapW'(cnt_q) >= eff_cap;
  assign match     = rd_vld_q && (rd_data_q == {ka_q, kb_q});
  assign issue     = (state_q == S_SCAN) && (ptr_q < cnt_q);
  assign done_miss = (state_q == S_SCAN) && !match && (ptr_q >= cnt_q);
  assign alloc_en  = done_miss && !full;
  assign out_free  = !out_valid_q || out_ready_i;
  assign out_load  = (state_q == S_ADD) && out_free;
  assign ok        = (rs_q == ST_HIT) || (rs_q == ST_ALLOC);
  assign addr_d    = base_q + 64'({prod_q, 1'b0});
  assign in_ready_o = (state_q == S_IDLE);

  always_ff @(posedge clk_i) begin
    if (issue) begin
      rd_data_q <= mem[ptr_q[IdxW-1:0]];
    end
    if (alloc_en) begin
      mem[cnt_q[IdxW-1:0]] <= {ka_q, kb_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q     <= 1'b0;
      cap_q    <= '0;
      stride_q <= '0;
      base_q   <= '0;
    end else if (cfg_wr) begin
      case (paddr[4:3])
        REG_ENABLE:   en_q     <= pwdata[0];
        REG_CAPACITY: cap_q    <= pwdata[8:0];
        REG_STRIDE:   stride_q <= pwdata[15:0];
        REG_BASE:     base_q   <= pwdata;
        default:      ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ka_q        <= '0;
      kb_q        <= '0;
      ptr_q       <= '0;
      cnt_q       <= '0;
      idx_q       <= '0;
      rs_q        <= ST_HIT;
      prod_q      <= '0;
      rd_vld_q    <= 1'b0;
      rd_idx_q    <= '0;
      out_valid_q <= 1'b0;
      status_q    <= ST_HIT;
      slot_q      <= '0;
      addr_q      <= '0;
      used_q      <= '0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          rd_vld_q <= 1'b0;
          if (in_valid_i) begin
            ka_q  <= key_hash_a_i;
            kb_q  <= key_hash_b_i;
            ptr_q <= '0;
            if (!en_q) begin
              rs_q    <= ST_NOEN;
              state_q <= S_ADD;
            end else begin
              state_q <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          rd_vld_q <= issue;
          rd_idx_q <= ptr_q[IdxW-1:0];
          if (issue) begin
            ptr_q <= ptr_q + 1'b1;
          end
          if (match) begin
            idx_q   <= rd_idx_q;
            rs_q    <= ST_HIT;
            state_q <= S_MUL;
          end else if (done_miss) begin
            if (full) begin
              rs_q    <= ST_FULL;
              state_q <= S_ADD;
            end else begin
              idx_q   <= cnt_q[IdxW-1:0];
              cnt_q   <= cnt_q + 1'b1;
              rs_q    <= ST_ALLOC;
              state_q <= S_MUL;
            end
          end
        end
        S_MUL: begin
          rd_vld_q <= 1'b0;
          prod_q   <= PrdW'(idx_q) * PrdW'(stride_q);
          state_q  <= S_ADD;
        end
        S_ADD: begin
          rd_vld_q <= 1'b0;
          if (out_free) begin
            status_q    <= rs_q;
            slot_q      <= ok ? 8'(idx_q) : 8'd0;
            addr_q      <= ok ? addr_d : 64'd0;
            used_q      <= 9'(cnt_q);
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign slot_index_o    = slot_q;
  assign table_address_o = addr_q;
  assign slots_used_o    = used_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(MAX_TABLES))
    else $error("slot count above capacity limit");

  a_cnt_inc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    alloc_en |=> cnt_q == $past(cnt_q) + 1'b1)
    else $error("allocation did not bump count");

  a_cnt_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !alloc_en |=> $stable(cnt_q))
    else $error("count changed without allocation");

  a_rd_written: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> CntW'(rd_idx_q) < cnt_q)
    else $error("read of unallocated slot");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (status_q == ST_NOEN || status_q == ST_FULL)
      |-> addr_q == 64'd0 && slot_q == 8'd0)
    else $error("failed request carries nonzero result");

endmodule
